/* rtl/lphd_pkg.sv */
// shared constants, types and helper functions of the hash dictionary
`timescale 1ns / 1ps

package lphd_pkg;

  localparam int TABLE_SLOTS   = 16;
  localparam int KEY_MAX_BYTES = 8;
  localparam int VALUE_BITS    = 32;

  localparam int KEY_BITS    = 64;
  localparam int LEN_BITS    = 4;
  localparam int SLOT_W      = $clog2(TABLE_SLOTS);
  // byte sum of a full key, 8 * 255 at most
  localparam int SUM_W       = 11;
  localparam int RECIP_SHIFT = 22;
  localparam int QUEUE_DEPTH = 2;

  localparam logic [SUM_W-1:0]       SLOTS_SUM = SUM_W'(TABLE_SLOTS);
  localparam logic [RECIP_SHIFT-1:0] RECIP     = RECIP_SHIFT'((1 << RECIP_SHIFT) / TABLE_SLOTS);
  localparam logic [LEN_BITS-1:0]    LEN_MAX   = LEN_BITS'(KEY_MAX_BYTES);

  localparam logic [1:0] FUNC_INSERT = 2'd0;
  localparam logic [1:0] FUNC_DELETE = 2'd1;
  localparam logic [1:0] FUNC_LOOKUP = 2'd2;

  localparam logic [1:0] STATUS_OK      = 2'd0;
  localparam logic [1:0] STATUS_MISSING = 2'd1;
  localparam logic [1:0] STATUS_FULL    = 2'd2;

  localparam logic [1:0] MARK_EMPTY = 2'd0;
  localparam logic [1:0] MARK_USED  = 2'd1;
  localparam logic [1:0] MARK_GONE  = 2'd2;

  typedef logic [SLOT_W-1:0]     slot_idx_t;
  typedef logic [VALUE_BITS-1:0] value_t;

  typedef struct packed {
    logic [1:0]  func;
    logic [63:0] key_bytes;
    logic [3:0]  key_length;
    logic [31:0] entry_value;
  } in_item_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [31:0] found_value;
    logic [3:0]  slot_index;
  } out_item_t;

  // classified item handed from front to back
  typedef struct packed {
    logic [1:0]          func;
    logic [KEY_BITS-1:0] key;
    logic [LEN_BITS-1:0] len;
    value_t              value;
    slot_idx_t           home;
  } desc_t;

  typedef struct packed {
    logic [1:0]          mark;
    logic [LEN_BITS-1:0] len;
    logic [KEY_BITS-1:0] key;
    value_t              value;
  } slot_t;

  function automatic slot_idx_t next_slot(input slot_idx_t idx);
    slot_idx_t res;
    if (idx == SLOT_W'(TABLE_SLOTS - 1)) res = '0;
    else res = idx + SLOT_W'(1);
    return res;
  endfunction

  function automatic logic [3:0] out_slot(input slot_idx_t idx);
    logic [SLOT_W+3:0] ext;
    ext = {4'b0, idx};
    return ext[3:0];
  endfunction

  function automatic logic [31:0] out_value(input value_t v);
    logic [VALUE_BITS+31:0] ext;
    ext = {32'b0, v};
    return ext[31:0];
  endfunction

  function automatic value_t in_value(input logic [31:0] v);
    logic [VALUE_BITS+31:0] ext;
    ext = {{VALUE_BITS{1'b0}}, v};
    return ext[VALUE_BITS-1:0];
  endfunction

endpackage

/* rtl/lphd_ram.sv */
// generic single write port ram with registered read
`timescale 1ns / 1ps

module lphd_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

/* rtl/lphd_front.sv */
// front end: key clean-up and home slot computation
`timescale 1ns / 1ps

module lphd_front (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               take,
  input  lphd_pkg::in_item_t in_item,
  output logic               busy,
  input  logic               q_full,
  output logic               q_push,
  output lphd_pkg::desc_t    q_data
);

  logic                               busy_r;
  logic                               phase_r;
  logic [1:0]                         func_r;
  logic [lphd_pkg::KEY_BITS-1:0]      key_r;
  logic [lphd_pkg::LEN_BITS-1:0]      len_r;
  lphd_pkg::value_t                   val_r;
  logic [lphd_pkg::SUM_W-1:0]         sum_r;
  logic [lphd_pkg::SUM_W-1:0]         q_r;

  logic [lphd_pkg::LEN_BITS-1:0]      len_sat;
  logic [lphd_pkg::KEY_BITS-1:0]      key_m;
  logic [lphd_pkg::SUM_W-1:0]         sum;
  logic [lphd_pkg::SUM_W+lphd_pkg::RECIP_SHIFT-1:0] prod;
  logic [lphd_pkg::SUM_W-1:0]         qn;
  logic [lphd_pkg::SUM_W-1:0]         rem;
  logic [lphd_pkg::SUM_W-1:0]         home_full;

  always_comb begin
    len_sat = (in_item.key_length > lphd_pkg::LEN_MAX) ? lphd_pkg::LEN_MAX
                                                        : in_item.key_length;
    key_m = '0;
    sum   = '0;
    for (int i = 0; i < 8; i++) begin
      if (i < int'(len_sat)) begin
        key_m[8*i +: 8] = in_item.key_bytes[8*i +: 8];
        sum = sum + lphd_pkg::SUM_W'(in_item.key_bytes[8*i +: 8]);
      end
    end
  end

  // quotient estimate by reciprocal, at most one short
  assign prod = (lphd_pkg::SUM_W+lphd_pkg::RECIP_SHIFT)'(sum_r) *
                (lphd_pkg::SUM_W+lphd_pkg::RECIP_SHIFT)'(lphd_pkg::RECIP);
  assign qn   = lphd_pkg::SUM_W'(q_r * lphd_pkg::SLOTS_SUM);
  assign rem  = sum_r - qn;
  assign home_full = (rem >= lphd_pkg::SLOTS_SUM) ? rem - lphd_pkg::SLOTS_SUM : rem;

  assign busy   = busy_r;
  assign q_push = busy_r && phase_r && !q_full;

  always_comb begin
    q_data.func  = func_r;
    q_data.key   = key_r;
    q_data.len   = len_r;
    q_data.value = val_r;
    q_data.home  = home_full[lphd_pkg::SLOT_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r  <= 1'b0;
      phase_r <= 1'b0;
    end else if (take) begin
      busy_r  <= 1'b1;
      phase_r <= 1'b0;
    end else if (busy_r && !phase_r) begin
      phase_r <= 1'b1;
    end else if (q_push) begin
      busy_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      func_r <= in_item.func;
      key_r  <= key_m;
      len_r  <= len_sat;
      val_r  <= lphd_pkg::in_value(in_item.entry_value);
      sum_r  <= sum;
    end
    if (busy_r && !phase_r) begin
      q_r <= prod[lphd_pkg::SUM_W+lphd_pkg::RECIP_SHIFT-1:lphd_pkg::RECIP_SHIFT];
    end
  end

endmodule

/* rtl/lphd_queue.sv */
// short fifo of classified items between front and back
`timescale 1ns / 1ps

module lphd_queue (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            push,
  input  lphd_pkg::desc_t push_data,
  output logic            full,
  input  logic            pop,
  output lphd_pkg::desc_t head,
  output logic            empty
);

  localparam int PTR_W = $clog2(lphd_pkg::QUEUE_DEPTH);

  lphd_pkg::desc_t  mem_r [lphd_pkg::QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr_r;
  logic [PTR_W-1:0] rd_ptr_r;
  logic [PTR_W:0]   count_r;

  function automatic logic [PTR_W-1:0] bump(input logic [PTR_W-1:0] p);
    logic [PTR_W-1:0] res;
    if (p == PTR_W'(lphd_pkg::QUEUE_DEPTH - 1)) res = '0;
    else res = p + PTR_W'(1);
    return res;
  endfunction

  assign full  = (count_r == (PTR_W+1)'(lphd_pkg::QUEUE_DEPTH));
  assign empty = (count_r == '0);
  assign head  = mem_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) wr_ptr_r <= bump(wr_ptr_r);
      if (pop)  rd_ptr_r <= bump(rd_ptr_r);
      if (push && !pop)      count_r <= count_r + (PTR_W+1)'(1);
      else if (pop && !push) count_r <= count_r - (PTR_W+1)'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

endmodule

/* rtl/lphd_back.sv */
// back end: probe walk over the slot ram, write-back and result register
`timescale 1ns / 1ps

module lphd_back (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                q_empty,
  input  lphd_pkg::desc_t     q_head,
  output logic                q_pop,
  output logic                clearing,
  output logic                out_empty,
  input  logic                out_pop,
  output lphd_pkg::out_item_t out_item
);

  localparam logic [1:0] ST_CLEAR  = 2'd0;
  localparam logic [1:0] ST_IDLE   = 2'd1;
  localparam logic [1:0] ST_PROBE  = 2'd2;
  localparam logic [1:0] ST_FINISH = 2'd3;

  logic [1:0]          state_r, state_nxt;
  lphd_pkg::slot_idx_t clr_idx_r;
  lphd_pkg::desc_t     cur_r;
  lphd_pkg::slot_idx_t chk_idx_r;
  lphd_pkg::slot_idx_t cnt_r;
  logic                have_gone_r, have_match_r, have_empty_r;
  lphd_pkg::slot_idx_t gone_at_r, match_at_r, empty_at_r;
  lphd_pkg::value_t    match_val_r;
  logic                out_valid_r;
  lphd_pkg::out_item_t out_item_r;

  logic                ram_we;
  lphd_pkg::slot_idx_t ram_waddr, ram_raddr;
  lphd_pkg::slot_t     ram_wdata, ram_rdata;

  logic                hit, stop_empty, is_gone, last_probe, finish_go;
  lphd_pkg::out_item_t res;
  logic                wr_slot;
  lphd_pkg::slot_idx_t wr_at;
  logic [1:0]          wr_mark;

  lphd_ram #(
    .WIDTH ($bits(lphd_pkg::slot_t)),
    .DEPTH (lphd_pkg::TABLE_SLOTS)
  ) u_slots (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign hit = (ram_rdata.mark == lphd_pkg::MARK_USED) && (ram_rdata.len == cur_r.len) &&
               (ram_rdata.key == cur_r.key);
  assign is_gone    = (ram_rdata.mark == lphd_pkg::MARK_GONE);
  // unused mark code counts as empty
  assign stop_empty = (ram_rdata.mark != lphd_pkg::MARK_USED) && !is_gone;
  assign last_probe = (cnt_r == lphd_pkg::SLOT_W'(lphd_pkg::TABLE_SLOTS - 1));
  assign finish_go  = (state_r == ST_FINISH) && (!out_valid_r || out_pop);

  assign q_pop     = (state_r == ST_IDLE) && !q_empty;
  assign clearing  = (state_r == ST_CLEAR);
  assign out_empty = !out_valid_r;
  assign out_item  = out_item_r;

  // outcome of the finished walk
  always_comb begin
    res     = '{status: lphd_pkg::STATUS_MISSING, found_value: 32'd0, slot_index: 4'd0};
    wr_slot = 1'b0;
    wr_at   = match_at_r;
    wr_mark = lphd_pkg::MARK_USED;
    priority if (cur_r.func == lphd_pkg::FUNC_INSERT) begin
      if (have_match_r)      wr_at = match_at_r;
      else if (have_gone_r)  wr_at = gone_at_r;
      else                   wr_at = empty_at_r;
      if (have_match_r || have_gone_r || have_empty_r) begin
        wr_slot        = 1'b1;
        res.status     = lphd_pkg::STATUS_OK;
        res.slot_index = lphd_pkg::out_slot(wr_at);
      end else begin
        res.status = lphd_pkg::STATUS_FULL;
      end
    end else if (cur_r.func == lphd_pkg::FUNC_DELETE) begin
      wr_mark = lphd_pkg::MARK_GONE;
      if (have_match_r) begin
        wr_slot        = 1'b1;
        res.status     = lphd_pkg::STATUS_OK;
        res.slot_index = lphd_pkg::out_slot(match_at_r);
      end
    end else begin
      if (have_match_r) begin
        res.status      = lphd_pkg::STATUS_OK;
        res.found_value = lphd_pkg::out_value(match_val_r);
        res.slot_index  = lphd_pkg::out_slot(match_at_r);
      end
    end
  end

  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = wr_at;
    ram_wdata = '{mark: wr_mark, len: cur_r.len, key: cur_r.key, value: cur_r.value};
    if (state_r == ST_CLEAR) begin
      ram_we    = 1'b1;
      ram_waddr = clr_idx_r;
      ram_wdata = '{mark: lphd_pkg::MARK_EMPTY, len: '0, key: '0, value: '0};
    end else if (finish_go) begin
      ram_we = wr_slot;
    end
  end

  // read address runs one slot ahead of the slot being checked
  always_comb begin
    unique case (state_r)
      ST_IDLE:  ram_raddr = q_head.home;
      ST_PROBE: ram_raddr = lphd_pkg::next_slot(chk_idx_r);
      default:  ram_raddr = chk_idx_r;
    endcase
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_CLEAR: begin
        if (clr_idx_r == lphd_pkg::SLOT_W'(lphd_pkg::TABLE_SLOTS - 1)) state_nxt = ST_IDLE;
      end
      ST_IDLE: begin
        if (!q_empty) state_nxt = ST_PROBE;
      end
      ST_PROBE: begin
        if (hit || stop_empty || last_probe) state_nxt = ST_FINISH;
      end
      ST_FINISH: begin
        if (finish_go) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_CLEAR;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      clr_idx_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (state_r == ST_CLEAR) clr_idx_r <= lphd_pkg::next_slot(clr_idx_r);
      if (finish_go)    out_valid_r <= 1'b1;
      else if (out_pop) out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      cur_r        <= q_head;
      chk_idx_r    <= q_head.home;
      cnt_r        <= '0;
      have_gone_r  <= 1'b0;
      have_match_r <= 1'b0;
      have_empty_r <= 1'b0;
    end else if (state_r == ST_PROBE) begin
      if (hit) begin
        have_match_r <= 1'b1;
        match_at_r   <= chk_idx_r;
        match_val_r  <= ram_rdata.value;
      end else if (stop_empty) begin
        have_empty_r <= 1'b1;
        empty_at_r   <= chk_idx_r;
      end else begin
        if (is_gone && !have_gone_r) begin
          have_gone_r <= 1'b1;
          gone_at_r   <= chk_idx_r;
        end
        chk_idx_r <= lphd_pkg::next_slot(chk_idx_r);
        cnt_r     <= cnt_r + lphd_pkg::SLOT_W'(1);
      end
    end
    if (finish_go) begin
      out_item_r <= res;
    end
  end

endmodule

/* rtl/linear_probe_hash_dictionary.sv */
// top level of the linear probing hash dictionary
`timescale 1ns / 1ps

// open addressing dictionary of lphd_pkg::TABLE_SLOTS slots, keys of up to eight bytes.
// func selects insert, delete or lookup (code three acts as lookup); each transaction
// gives exactly one result. the front takes an item, masks the key, registers it with
// its byte sum, then the reciprocal quotient, and so works out the home slot (byte sum
// modulo table size); it hands that through a two-entry queue to the back. the back
// walks the slot ram one slot per cycle: a start step reading the home slot, a check of
// each slot (1 to TABLE_SLOTS of them), then write-back and the result, held off while
// the last result is untaken; one item at a time, bound by the single slot ram read port.
// after reset a clearing pass marks every slot empty; full stays high until it ends.

module linear_probe_hash_dictionary (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_push,
  output logic                in_full,
  input  lphd_pkg::in_item_t  in_item,
  output logic                out_empty,
  input  logic                out_pop,
  output lphd_pkg::out_item_t out_item
);

  logic            front_busy;
  logic            clearing;
  logic            take;
  logic            q_push, q_full, q_pop, q_empty;
  lphd_pkg::desc_t q_data, q_head;

  assign in_full = front_busy || clearing;
  assign take    = in_push && !in_full;

  lphd_front u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .take    (take),
    .in_item (in_item),
    .busy    (front_busy),
    .q_full  (q_full),
    .q_push  (q_push),
    .q_data  (q_data)
  );

  lphd_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_data (q_data),
    .full      (q_full),
    .pop       (q_pop),
    .head      (q_head),
    .empty     (q_empty)
  );

  lphd_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_empty   (q_empty),
    .q_head    (q_head),
    .q_pop     (q_pop),
    .clearing  (clearing),
    .out_empty (out_empty),
    .out_pop   (out_pop),
    .out_item  (out_item)
  );

endmodule
